// File: rtl/lrcs_pkg.sv
// ----------------------------------------------------------------------------
// lrcs_pkg
// Shared types and constants of the LED ring cross-fade sequencer.
// ----------------------------------------------------------------------------
package lrcs_pkg;

   localparam int LedCountDefault = 16;
   localparam int LevelW          = 8;
   localparam int LedW            = 4;
   localparam int OpW             = 2;
   localparam int CsrIndexW       = 1;

   localparam logic [LevelW-1:0] StepSizeReset = 8'd6;
   localparam logic [LevelW-1:0] MaxLevelReset = 8'd255;

   localparam logic [CsrIndexW-1:0] CSR_STEP_SIZE = 1'b0;
   localparam logic [CsrIndexW-1:0] CSR_MAX_LEVEL = 1'b1;

   typedef enum logic [OpW-1:0] {
      OP_TICK   = 2'd0,
      OP_ATTACH = 2'd1,
      OP_DETACH = 2'd2
   } op_type;

   typedef enum logic {
      ALU_FALL = 1'b0,
      ALU_RISE = 1'b1
   } alu_mode_type;

   typedef struct packed {
      logic [LevelW-1:0] level;
      logic              done;
   } alu_res_type;

endpackage

// File: rtl/lrcs_ram.sv
// ----------------------------------------------------------------------------
// lrcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lrcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

// File: rtl/lrcs_alu.sv
// ----------------------------------------------------------------------------
// lrcs_alu
// Shared level unit: one adder serves the falling subtract with floor at zero
// and the rising add with clamp at the maximum level.
// ----------------------------------------------------------------------------
module lrcs_alu (
   input  lrcs_pkg::alu_mode_type       mode,
   input  logic [lrcs_pkg::LevelW-1:0]  cur_level,
   input  logic [lrcs_pkg::LevelW-1:0]  step_size,
   input  logic [lrcs_pkg::LevelW-1:0]  max_level,
   output lrcs_pkg::alu_res_type        res
);

   import lrcs_pkg::*;

   logic [LevelW-1:0] operand_b;
   logic              carry_in;
   logic [LevelW:0]   sum;
   logic              above_step;
   logic              above_max;

   always_comb begin
      operand_b  = (mode == ALU_RISE) ? step_size : ~step_size;
      carry_in   = (mode == ALU_RISE) ? 1'b0 : 1'b1;
      sum        = {1'b0, cur_level} + {1'b0, operand_b} + {{LevelW{1'b0}}, carry_in};
      above_step = sum[LevelW] && (sum[LevelW-1:0] != '0);
      above_max  = sum > {1'b0, max_level};
      if (mode == ALU_RISE) begin
         res.done  = above_max;
         res.level = above_max ? max_level : sum[LevelW-1:0];
      end else begin
         res.done  = !above_step;
         res.level = above_step ? sum[LevelW-1:0] : '0;
      end
   end

endmodule

// File: rtl/led_ring_crossfade_sequencer.sv
// ----------------------------------------------------------------------------
// led_ring_crossfade_sequencer
// Cross-fades the attached LEDs of a ring: one falling and one rising slot,
// per-LED levels in a RAM, a shared level unit and a ring scanner.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_stall    req_operation, req_led_index
//   rsp      out  rsp_valid/rsp_stall    rsp_led_number, rsp_level, rsp_last
//   csr      in   csr_write              csr_index, csr_data
//
// One request at a time. Attach is handled in the idle state; detach may add a
// ring scan over up to LED_COUNT LEDs. A tick reads and then writes each active
// slot (RAM read, then level unit and write), then updates the slots, plus a
// ring scan over up to LED_COUNT LEDs when both slots finish.
// Reset clears all levels, members and slots at once through valid flags.
// A stalled response holds the sequencer in its write state.
// ----------------------------------------------------------------------------
module led_ring_crossfade_sequencer #(
   parameter int LED_COUNT = lrcs_pkg::LedCountDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lrcs_pkg::OpW-1:0]       req_operation,
   input  logic [lrcs_pkg::LedW-1:0]      req_led_index,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lrcs_pkg::LedW-1:0]      rsp_led_number,
   output logic [lrcs_pkg::LevelW-1:0]    rsp_level,
   output logic                           rsp_last,
   input  logic                           csr_write,
   input  logic [lrcs_pkg::CsrIndexW-1:0] csr_index,
   input  logic [lrcs_pkg::LevelW-1:0]    csr_data
);

   import lrcs_pkg::*;

   localparam int IdxW = $clog2(LED_COUNT);
   localparam int CntW = $clog2(LED_COUNT + 1);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_RD_F = 7'b0000010,
      ST_WR_F = 7'b0000100,
      ST_RD_R = 7'b0001000,
      ST_WR_R = 7'b0010000,
      ST_FIN  = 7'b0100000,
      ST_SCAN = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [LevelW-1:0]     step_size_ff, step_size_in;
   logic [LevelW-1:0]     max_level_ff, max_level_in;
   logic [LED_COUNT-1:0]  members_ff, members_in;
   logic [LED_COUNT-1:0]  lvl_valid_ff, lvl_valid_in;
   logic                  falling_valid_ff, falling_valid_in;
   logic [IdxW-1:0]       falling_led_ff, falling_led_in;
   logic                  rising_valid_ff, rising_valid_in;
   logic [IdxW-1:0]       rising_led_ff, rising_led_in;
   logic                  done_f_ff, done_f_in;
   logic                  done_r_ff, done_r_in;
   logic [IdxW-1:0]       scan_ptr_ff, scan_ptr_in;
   logic [CntW-1:0]       scan_cnt_ff, scan_cnt_in;
   logic [IdxW-1:0]       scan_base_ff, scan_base_in;
   logic                  scan_rise_ff, scan_rise_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LedW-1:0]       rsp_led_ff, rsp_led_in;
   logic [LevelW-1:0]     rsp_level_ff, rsp_level_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  ram_we;
   logic [IdxW-1:0]       rd_led;
   logic [LevelW-1:0]     ram_rdata;
   logic [LevelW-1:0]     cur_level;
   alu_mode_type          alu_mode;
   alu_res_type           alu_res;
   logic                  out_free;
   logic [IdxW-1:0]       idx_led;
   logic                  idx_ok;

   function automatic logic [IdxW-1:0] ring_inc(input logic [IdxW-1:0] p);
      ring_inc = (p == IdxW'(LED_COUNT - 1)) ? '0 : p + 1'b1;
   endfunction

   lrcs_ram #(
      .WIDTH (LevelW),
      .DEPTH (LED_COUNT)
   ) u_levels (
      .clock        (clock),
      .write_enable (ram_we),
      .write_addr   (rd_led),
      .write_data   (alu_res.level),
      .read_addr    (rd_led),
      .read_data    (ram_rdata)
   );

   lrcs_alu u_alu (
      .mode      (alu_mode),
      .cur_level (cur_level),
      .step_size (step_size_ff),
      .max_level (max_level_ff),
      .res       (alu_res)
   );

   assign rd_led    = (state_ff == ST_RD_R || state_ff == ST_WR_R) ? rising_led_ff
                                                                   : falling_led_ff;
   assign cur_level = lvl_valid_ff[rd_led] ? ram_rdata : '0;
   assign alu_mode  = (state_ff == ST_WR_R) ? ALU_RISE : ALU_FALL;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign idx_led   = IdxW'(req_led_index);
   assign idx_ok    = int'(req_led_index) < LED_COUNT;

   always_comb begin
      state_in         = state_ff;
      step_size_in     = step_size_ff;
      max_level_in     = max_level_ff;
      members_in       = members_ff;
      lvl_valid_in     = lvl_valid_ff;
      falling_valid_in = falling_valid_ff;
      falling_led_in   = falling_led_ff;
      rising_valid_in  = rising_valid_ff;
      rising_led_in    = rising_led_ff;
      done_f_in        = done_f_ff;
      done_r_in        = done_r_ff;
      scan_ptr_in      = scan_ptr_ff;
      scan_cnt_in      = scan_cnt_ff;
      scan_base_in     = scan_base_ff;
      scan_rise_in     = scan_rise_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_led_in       = rsp_led_ff;
      rsp_level_in     = rsp_level_ff;
      rsp_last_in      = rsp_last_ff;
      ram_we           = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write) begin
         unique case (csr_index)
            CSR_STEP_SIZE: step_size_in = csr_data;
            CSR_MAX_LEVEL: max_level_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (op_type'(req_operation))
                  OP_TICK: begin
                     if (falling_valid_ff || rising_valid_ff) begin
                        done_f_in = 1'b0;
                        done_r_in = 1'b0;
                        state_in  = falling_valid_ff ? ST_RD_F : ST_RD_R;
                     end
                  end
                  OP_ATTACH: begin
                     if (idx_ok && !members_ff[idx_led]) begin
                        members_in[idx_led] = 1'b1;
                        if (!falling_valid_ff) begin
                           falling_led_in   = idx_led;
                           falling_valid_in = 1'b1;
                        end else if (!rising_valid_ff) begin
                           rising_led_in   = idx_led;
                           rising_valid_in = 1'b1;
                        end
                     end
                  end
                  OP_DETACH: begin
                     if (idx_ok && members_ff[idx_led]) begin
                        members_in[idx_led] = 1'b0;
                        if (rising_valid_ff && rising_led_ff == idx_led) begin
                           rising_valid_in = 1'b0;
                           if (falling_valid_ff) begin
                              scan_base_in = falling_led_ff;
                              scan_rise_in = 1'b1;
                              scan_ptr_in  = members_ff[falling_led_ff]
                                             ? ring_inc(falling_led_ff) : '0;
                              scan_cnt_in  = CntW'(LED_COUNT);
                              state_in     = ST_SCAN;
                           end
                        end else if (falling_valid_ff && falling_led_ff == idx_led) begin
                           falling_valid_in = 1'b0;
                           if (rising_valid_ff) begin
                              scan_base_in = rising_led_ff;
                              scan_rise_in = 1'b0;
                              scan_ptr_in  = members_ff[rising_led_ff]
                                             ? ring_inc(rising_led_ff) : '0;
                              scan_cnt_in  = CntW'(LED_COUNT);
                              state_in     = ST_SCAN;
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RD_F: state_in = ST_WR_F;
         ST_WR_F: begin
            if (out_free) begin
               ram_we               = 1'b1;
               lvl_valid_in[rd_led] = 1'b1;
               done_f_in            = alu_res.done;
               rsp_valid_in         = 1'b1;
               rsp_led_in           = LedW'(falling_led_ff);
               rsp_level_in         = alu_res.level;
               rsp_last_in          = !rising_valid_ff;
               state_in             = rising_valid_ff ? ST_RD_R : ST_FIN;
            end
         end
         ST_RD_R: state_in = ST_WR_R;
         ST_WR_R: begin
            if (out_free) begin
               ram_we               = 1'b1;
               lvl_valid_in[rd_led] = 1'b1;
               done_r_in            = alu_res.done;
               rsp_valid_in         = 1'b1;
               rsp_led_in           = LedW'(rising_led_ff);
               rsp_level_in         = alu_res.level;
               rsp_last_in          = 1'b1;
               state_in             = ST_FIN;
            end
         end
         ST_FIN: begin
            state_in = ST_IDLE;
            if (done_f_ff && !rising_valid_ff) begin
               rising_led_in    = falling_led_ff;
               rising_valid_in  = 1'b1;
               falling_valid_in = 1'b0;
            end else if (done_r_ff && !falling_valid_ff) begin
               falling_led_in   = rising_led_ff;
               falling_valid_in = 1'b1;
               rising_valid_in  = 1'b0;
            end else if (done_f_ff && done_r_ff) begin
               falling_led_in   = rising_led_ff;
               falling_valid_in = 1'b1;
               rising_valid_in  = 1'b0;
               scan_base_in     = rising_led_ff;
               scan_rise_in     = 1'b1;
               scan_ptr_in      = members_ff[rising_led_ff] ? ring_inc(rising_led_ff) : '0;
               scan_cnt_in      = CntW'(LED_COUNT);
               state_in         = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (members_ff[scan_ptr_ff]) begin
               state_in = ST_IDLE;
               if (scan_ptr_ff != scan_base_ff) begin
                  if (scan_rise_ff) begin
                     rising_led_in   = scan_ptr_ff;
                     rising_valid_in = 1'b1;
                  end else begin
                     falling_led_in   = scan_ptr_ff;
                     falling_valid_in = 1'b1;
                  end
               end
            end else if (scan_cnt_ff == CntW'(1)) begin
               state_in = ST_IDLE;
            end else begin
               scan_ptr_in = ring_inc(scan_ptr_ff);
               scan_cnt_in = scan_cnt_ff - 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         step_size_ff     <= StepSizeReset;
         max_level_ff     <= MaxLevelReset;
         members_ff       <= '0;
         lvl_valid_ff     <= '0;
         falling_valid_ff <= 1'b0;
         falling_led_ff   <= '0;
         rising_valid_ff  <= 1'b0;
         rising_led_ff    <= '0;
         done_f_ff        <= 1'b0;
         done_r_ff        <= 1'b0;
         scan_cnt_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         step_size_ff     <= step_size_in;
         max_level_ff     <= max_level_in;
         members_ff       <= members_in;
         lvl_valid_ff     <= lvl_valid_in;
         falling_valid_ff <= falling_valid_in;
         falling_led_ff   <= falling_led_in;
         rising_valid_ff  <= rising_valid_in;
         rising_led_ff    <= rising_led_in;
         done_f_ff        <= done_f_in;
         done_r_ff        <= done_r_in;
         scan_cnt_ff      <= scan_cnt_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      scan_ptr_ff  <= scan_ptr_in;
      scan_base_ff <= scan_base_in;
      scan_rise_ff <= scan_rise_in;
      rsp_led_ff   <= rsp_led_in;
      rsp_level_ff <= rsp_level_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_led_number = rsp_led_ff;
   assign rsp_level      = rsp_level_ff;
   assign rsp_last       = rsp_last_ff;

   a_slots_distinct: assert property (@(posedge clock) disable iff (reset)
      falling_valid_ff && rising_valid_ff |-> falling_led_ff != rising_led_ff)
      else $error("falling and rising slots hold the same LED");

   a_falling_member: assert property (@(posedge clock) disable iff (reset)
      falling_valid_ff |-> members_ff[falling_led_ff])
      else $error("falling slot holds a detached LED");

   a_rising_member: assert property (@(posedge clock) disable iff (reset)
      rising_valid_ff |-> members_ff[rising_led_ff])
      else $error("rising slot holds a detached LED");

   a_scan_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> scan_cnt_ff != '0)
      else $error("ring scan ran past its step count");

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LED ring cross-fade sequencer. A behavioural
// copy of the ring (levels, members, falling and rising slots) predicts the
// brightness updates of every accepted request; a checker compares each
// response against the oldest prediction. Directed sequences cover the slot
// hand-overs and level limits, then random phases run under several step and
// maximum settings, all but the last with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lrcs_pkg::*;

   localparam int LedCount      = LedCountDefault;
   localparam int SettleCycles  = 48;
   localparam int WatchdogLimit = 3000;
   localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [LedW-1:0]   led;
      logic [LevelW-1:0] level;
      logic              last;
   } update_type;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   logic [OpW-1:0]       req_operation  = '0;
   logic [LedW-1:0]      req_led_index  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   logic [LedW-1:0]      rsp_led_number;
   logic [LevelW-1:0]    rsp_level;
   logic                 rsp_last;
   logic                 csr_write      = 1'b0;
   logic [CsrIndexW-1:0] csr_index      = '0;
   logic [LevelW-1:0]    csr_data       = '0;

   logic [LevelW-1:0] level_mem [LedCount];
   bit                member_set [LedCount];
   bit                fall_on;
   bit                rise_on;
   logic [LedW-1:0]   fall_led;
   logic [LedW-1:0]   rise_led;
   logic [LevelW-1:0] step_cfg;
   logic [LevelW-1:0] max_cfg;
   update_type        due_updates [$];

   int mismatches   = 0;
   int quiet_cycles = 0;
   int gap_pct      = 0;
   int stall_pct    = 0;
   int stall_hold   = 0;

   led_ring_crossfade_sequencer #(.LED_COUNT(LedCount)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_led_index  (req_led_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_led_number (rsp_led_number),
      .rsp_level      (rsp_level),
      .rsp_last       (rsp_last),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit ring_successor(input logic [LedW-1:0] led,
                                         output logic [LedW-1:0] found);
      int k;
      found = '0;
      if (member_set[led]) begin
         for (int i = 1; i <= LedCount; i++) begin
            k = (int'(led) + i) % LedCount;
            if (member_set[k]) begin
               found = LedW'(k);
               return 1'b1;
            end
         end
      end
      for (int i = 0; i < LedCount; i++) begin
         if (member_set[i]) begin
            found = LedW'(i);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   task automatic predict_ring_request(input logic [OpW-1:0] op,
                                       input logic [LedW-1:0] idx);
      logic [LevelW-1:0] fall_lvl;
      logic [LevelW-1:0] rise_lvl;
      logic [LevelW:0]   sum;
      logic [LedW-1:0]   nxt;
      bit                fall_done;
      bit                rise_done;
      update_type        upd;
      fall_lvl  = '0;
      rise_lvl  = '0;
      fall_done = 1'b0;
      rise_done = 1'b0;
      unique case (op)
         OP_TICK: begin
            if (fall_on || rise_on) begin
               if (fall_on) begin
                  if (level_mem[fall_led] > step_cfg) begin
                     fall_lvl = level_mem[fall_led] - step_cfg;
                  end else begin
                     fall_lvl  = '0;
                     fall_done = 1'b1;
                  end
                  level_mem[fall_led] = fall_lvl;
               end
               if (rise_on) begin
                  sum = {1'b0, level_mem[rise_led]} + {1'b0, step_cfg};
                  if (sum > {1'b0, max_cfg}) begin
                     rise_lvl  = max_cfg;
                     rise_done = 1'b1;
                  end else begin
                     rise_lvl = sum[LevelW-1:0];
                  end
                  level_mem[rise_led] = rise_lvl;
               end
               if (fall_on) begin
                  upd.led   = fall_led;
                  upd.level = fall_lvl;
                  upd.last  = !rise_on;
                  due_updates.push_back(upd);
               end
               if (rise_on) begin
                  upd.led   = rise_led;
                  upd.level = rise_lvl;
                  upd.last  = 1'b1;
                  due_updates.push_back(upd);
               end
               if (fall_done && !rise_on) begin
                  rise_led = fall_led;
                  rise_on  = 1'b1;
                  fall_on  = 1'b0;
               end else if (rise_done && !fall_on) begin
                  fall_led = rise_led;
                  fall_on  = 1'b1;
                  rise_on  = 1'b0;
               end else if (fall_done && rise_done) begin
                  fall_led = rise_led;
                  fall_on  = 1'b1;
                  if (ring_successor(fall_led, nxt) && nxt != fall_led) begin
                     rise_led = nxt;
                     rise_on  = 1'b1;
                  end else begin
                     rise_on = 1'b0;
                  end
               end
            end
         end
         OP_ATTACH: begin
            if (!member_set[idx]) begin
               member_set[idx] = 1'b1;
               if (!fall_on) begin
                  fall_led = idx;
                  fall_on  = 1'b1;
               end else if (!rise_on) begin
                  rise_led = idx;
                  rise_on  = 1'b1;
               end
            end
         end
         OP_DETACH: begin
            if (member_set[idx]) begin
               member_set[idx] = 1'b0;
               if (rise_on && rise_led == idx) begin
                  rise_on = 1'b0;
                  if (fall_on && ring_successor(fall_led, nxt) && nxt != fall_led) begin
                     rise_led = nxt;
                     rise_on  = 1'b1;
                  end
               end else if (fall_on && fall_led == idx) begin
                  fall_on = 1'b0;
                  if (rise_on && ring_successor(rise_led, nxt) && nxt != rise_led) begin
                     fall_led = nxt;
                     fall_on  = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   // hold the payload until the request is taken
   task automatic send_request(input logic [OpW-1:0] op, input logic [LedW-1:0] idx);
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_operation <= op;
      req_led_index <= idx;
      req_valid     <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_ring_request(op, idx);
   endtask

   task automatic drain_updates();
      req_valid <= 1'b0;
      while (due_updates.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrIndexW-1:0] idx,
                                 input logic [LevelW-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_STEP_SIZE) step_cfg = data;
      else max_cfg = data;
   endtask

   task automatic test_basic_sequencing();
      send_request(OP_TICK, 4'd0);
      send_request(OP_DETACH, 4'd5);
      send_request(OP_UNUSED, 4'd15);
      send_request(OP_ATTACH, 4'd15);
      send_request(OP_ATTACH, 4'd15);
      send_request(OP_TICK, 4'd9);
      send_request(OP_TICK, 4'd0);
      send_request(OP_ATTACH, 4'd0);
      send_request(OP_DETACH, 4'd0);
      send_request(OP_ATTACH, 4'd0);
      send_request(OP_ATTACH, 4'd7);
      send_request(OP_TICK, 4'd15);
      send_request(OP_DETACH, 4'd15);
      send_request(OP_TICK, 4'd0);
   endtask

   task automatic test_level_limits();
      drain_updates();
      write_register(CSR_STEP_SIZE, 8'd255);
      write_register(CSR_MAX_LEVEL, 8'd255);
      repeat (4) send_request(OP_TICK, 4'd0);
      drain_updates();
      write_register(CSR_MAX_LEVEL, 8'd1);
      repeat (3) send_request(OP_TICK, 4'd0);
      drain_updates();
      write_register(CSR_STEP_SIZE, 8'd0);
      repeat (2) send_request(OP_TICK, 4'd0);
   endtask

   task automatic test_random_traffic(input int count, input logic [LevelW-1:0] step,
                                      input logic [LevelW-1:0] maxl, input bit calm);
      int          span;
      int          base;
      int          pick;
      int          k;
      logic [LedW-1:0] idx;
      drain_updates();
      write_register(CSR_STEP_SIZE, step);
      write_register(CSR_MAX_LEVEL, maxl);
      span = 16;
      base = 0;
      for (int n = 0; n < count; n++) begin
         if (n % 64 == 0) begin
            gap_pct   = calm ? 0 : ($urandom_range(0, 2) * 20);
            stall_pct = calm ? 0 : ($urandom_range(0, 2) * 20);
            case ($urandom_range(0, 2))
               0: span = 2;
               1: span = 5;
               default: span = 16;
            endcase
            base = $urandom_range(0, 15);
         end
         idx  = LedW'((base + $urandom_range(0, span - 1)) % LedCount);
         pick = $urandom_range(0, 99);
         if (pick < 58) begin
            send_request(OP_TICK, LedW'($urandom_range(0, 15)));
         end else if (pick < 78) begin
            send_request(OP_ATTACH, idx);
         end else if (pick < 96) begin
            if ($urandom_range(0, 3) != 0) begin
               base = $urandom_range(0, 15);
               for (int i = 0; i < LedCount; i++) begin
                  k = (base + i) % LedCount;
                  if (member_set[k]) begin
                     idx = LedW'(k);
                     break;
                  end
               end
            end
            send_request(OP_DETACH, idx);
         end else begin
            send_request(OP_UNUSED, LedW'($urandom_range(0, 15)));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_hold = 0;
      end else if (stall_hold > 0) begin
         stall_hold--;
      end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
         rsp_stall  <= 1'b1;
         stall_hold = $urandom_range(0, 15);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_updates
      update_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_updates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected update led %0d level %0d last %0d",
                        $realtime, rsp_led_number, rsp_level, rsp_last);
         end else begin
            want = due_updates.pop_front();
            if (rsp_led_number !== want.led || rsp_level !== want.level ||
                rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: expected %0d/%0d/%0d, got %0d/%0d/%0d (led/level/last)",
                           $realtime, want.led, want.level, want.last,
                           rsp_led_number, rsp_level, rsp_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_write || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      while (quiet_cycles < WatchdogLimit) @(posedge clock);
      $display("FAIL led_ring_crossfade_sequencer");
      $finish;
   end

   initial begin : run
      for (int i = 0; i < LedCount; i++) begin
         level_mem[i]  = '0;
         member_set[i] = 1'b0;
      end
      fall_on  = 1'b0;
      rise_on  = 1'b0;
      fall_led = '0;
      rise_led = '0;
      step_cfg = StepSizeReset;
      max_cfg  = MaxLevelReset;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      gap_pct   = 20;
      stall_pct = 20;
      test_basic_sequencing();
      test_level_limits();
      test_random_traffic(200, LevelW'($urandom_range(1, 40)), 8'd255, 1'b0);
      test_random_traffic(200, 8'd1, LevelW'($urandom_range(1, 20)), 1'b0);
      test_random_traffic(200, 8'd255, 8'd1, 1'b0);
      test_random_traffic(200, LevelW'($urandom_range(0, 255)),
                          LevelW'($urandom_range(1, 255)), 1'b0);
      test_random_traffic(200, LevelW'($urandom_range(1, 64)),
                          LevelW'($urandom_range(1, 255)), 1'b1);
      drain_updates();
      if (due_updates.size() != 0) mismatches += due_updates.size();
      if (mismatches == 0)
         $display("PASS led_ring_crossfade_sequencer");
      else
         $display("FAIL led_ring_crossfade_sequencer");
      $finish;
   end

endmodule
